// ===== design/dbl_pkg.sv =====
`timescale 1ns / 1ps

package dbl_pkg;

    // Field and register widths.
    localparam int SAMPLE_W  = 32;
    localparam int PLANE_W   = 32;
    localparam int SCALE_W   = 16;
    localparam int DEPTH_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Arithmetic widths.
    localparam int Z24_W  = 25;               // Q0.24 depth, 1.0 included
    localparam int NF_W   = 2 * PLANE_W;      // near * far
    localparam int PROD_W = PLANE_W + Z24_W;  // one term of the denominator
    localparam int DEN_W  = PROD_W + 1;       // sum of both terms
    localparam int NUM1_W = NF_W + SCALE_W;   // near * far * scale
    localparam int NUM_SH = 8;
    localparam int REM_W  = NUM1_W + NUM_SH;  // numerator, Q48.40 scaled
    localparam int QUO_W  = 17;               // quotient bits 16 down to 0
    localparam int DSH_W  = DEN_W + QUO_W - 1;
    localparam int LIM_W  = DEPTH_W;
    localparam int LIMX_W = SCALE_W + 3;      // five times the scale

    localparam int CELL_COUNT = QUO_W;

    localparam logic [Z24_W-1:0]  Z_ONE      = Z24_W'(1) << 24;
    localparam logic [2:0]        LIMIT_MULT = 3'd5;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;

    // Register reset values.
    localparam logic [PLANE_W-1:0] NEAR_RST  = 32'd6554;
    localparam logic [PLANE_W-1:0] FAR_RST   = 32'd655360;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd1000;

    // State that travels down the divider chain with each sample.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DSH_W-1:0] dsh;
        logic [QUO_W-1:0] qbit;
        logic [QUO_W-1:0] quo;
        logic [LIM_W-1:0] lim;
        logic             zero;
    } dbl_stage_t;

endpackage

// ===== design/dbl_front.sv =====
`timescale 1ns / 1ps

module dbl_front
    import dbl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [PLANE_W-1:0]  near_plane,
    input  logic [PLANE_W-1:0]  far_plane,
    input  logic [SCALE_W-1:0]  scale_factor,
    output logic                dn_valid,
    input  logic                dn_ready,
    output dbl_stage_t          dn_data
);

    // Clamp a finite float to [0,1] and truncate it to Q0.24.
    function automatic logic [Z24_W-1:0] to_q24(input logic [SAMPLE_W-1:0] bits);
        logic [7:0]  ex;
        logic [23:0] sig;
        logic [7:0]  sh;
        logic [Z24_W-1:0] res;
        ex  = bits[30:23];
        sig = {1'b1, bits[22:0]};
        if (ex == 8'd0)
        begin
            ex  = 8'd1;
            sig = {1'b0, bits[22:0]};
        end
        sh = 8'd126 - ex;
        if (bits[31])
            res = '0;
        else if (bits[30:23] >= 8'd127)
            res = Z_ONE;
        else if (sh >= 8'd32)
            res = '0;
        else
            res = Z24_W'(sig >> sh);
        return res;
    endfunction

    logic              a_valid_reg;
    logic [Z24_W-1:0]  a_z24_reg;
    logic              a_special_reg;
    logic [NF_W-1:0]   a_nf_reg;

    logic              b_valid_reg;
    logic [PROD_W-1:0] b_fz_reg;
    logic [PROD_W-1:0] b_nz_reg;
    logic [NUM1_W-1:0] b_num1_reg;
    logic [LIM_W-1:0]  b_lim_reg;
    logic              b_special_reg;

    logic              c_valid_reg;
    dbl_stage_t        c_data_reg;

    logic a_ready;
    logic b_ready;
    logic c_ready;
    logic [LIMX_W-1:0] lim_wide;
    logic [DEN_W-1:0]  den_sum;

    assign c_ready  = !c_valid_reg || dn_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;

    assign lim_wide = LIMX_W'(scale_factor) * LIMX_W'(LIMIT_MULT);
    assign den_sum  = DEN_W'(b_fz_reg) + DEN_W'(b_nz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= up_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_z24_reg     <= to_q24(sample);
            a_special_reg <= (sample[30:23] == 8'hFF);
            a_nf_reg      <= NF_W'(near_plane) * NF_W'(far_plane);
        end
        if (b_ready && a_valid_reg)
        begin
            b_fz_reg      <= PROD_W'(far_plane) * PROD_W'(Z_ONE - a_z24_reg);
            b_nz_reg      <= PROD_W'(near_plane) * PROD_W'(a_z24_reg);
            b_num1_reg    <= NUM1_W'(a_nf_reg) * NUM1_W'(scale_factor);
            b_lim_reg     <= (lim_wide > LIMX_W'(16'hFFFF)) ? 16'hFFFF : lim_wide[LIM_W-1:0];
            b_special_reg <= a_special_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_data_reg.rem  <= {b_num1_reg, {NUM_SH{1'b0}}};
            c_data_reg.dsh  <= DSH_W'(den_sum) << (QUO_W - 1);
            c_data_reg.qbit <= QUO_W'(1) << (QUO_W - 1);
            c_data_reg.quo  <= '0;
            c_data_reg.lim  <= b_lim_reg;
            c_data_reg.zero <= b_special_reg || (den_sum == '0);
        end
    end

    assign dn_valid = c_valid_reg;
    assign dn_data  = c_data_reg;

endmodule

// ===== design/dbl_cell.sv =====
`timescale 1ns / 1ps

module dbl_cell
    import dbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  dbl_stage_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output dbl_stage_t dn_data
);

    logic       valid_reg;
    dbl_stage_t data_reg;
    dbl_stage_t data_next;
    logic [QUO_W-1:0] trial;
    logic take;

    assign up_ready = !valid_reg || dn_ready;

    // Try the current quotient bit: keep it if it stays within the limit
    // and the shifted divisor still fits in the remainder.
    assign trial = up_data.quo | up_data.qbit;
    assign take  = (REM_W'(up_data.dsh) <= up_data.rem) && (trial <= QUO_W'(up_data.lim));

    always_comb
    begin
        data_next      = up_data;
        data_next.dsh  = up_data.dsh >> 1;
        data_next.qbit = up_data.qbit >> 1;
        if (take)
        begin
            data_next.rem = up_data.rem - REM_W'(up_data.dsh);
            data_next.quo = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== design/depth_buffer_linearize_u16.sv =====
`timescale 1ns / 1ps
// Throughput: one sample per cycle while out_stall is low. Three front stages, seventeen
// divider cells and the output register each hold one sample, and every stage moves on
// whenever the stage after it has room.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and loads the registers
// with near 6554, far 655360 and scale 1000 (near 0.1, far 10.0 in Q16.16).
module depth_buffer_linearize_u16
    import dbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  depth_sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DEPTH_W-1:0]   depth_out
);

    // Configuration registers. They must only be written while no sample is in flight
    // (the block does not enforce this), so every stage may read them directly.
    logic [PLANE_W-1:0] near_reg;
    logic [PLANE_W-1:0] far_reg;
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg  <= NEAR_RST;
            far_reg   <= FAR_RST;
            scale_reg <= SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_NEAR:  near_reg  <= wr_data;
                REG_FAR:   far_reg   <= wr_data;
                REG_SCALE: scale_reg <= wr_data[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Pipeline handshake. Each stage is ready when it is empty or when the
    // stage after it is ready, so bubbles are squeezed out and a new sample
    // can enter while a finished result is still waiting at the output.
    logic       cell_valid [0:CELL_COUNT];
    logic       cell_ready [0:CELL_COUNT];
    dbl_stage_t cell_data  [0:CELL_COUNT];
    logic       front_ready;

    assign in_stall = !front_ready;

    // Front: decode the float, form the numerator near*far*scale*2^8 and the
    // denominator far*(1-z) + near*z in Q16.40, and the output limit.
    dbl_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (in_valid),
        .up_ready     (front_ready),
        .sample       (depth_sample),
        .near_plane   (near_reg),
        .far_plane    (far_reg),
        .scale_factor (scale_reg),
        .dn_valid     (cell_valid[0]),
        .dn_ready     (cell_ready[0]),
        .dn_data      (cell_data[0])
    );

    // Restoring divider: one cell per quotient bit, most significant first.
    // Each cell compares the shifted denominator against the remaining
    // numerator, subtracts when it fits and the limit allows the bit, and
    // hands the halved denominator to its neighbor.
    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        dbl_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cell_valid[i]),
            .up_ready (cell_ready[i]),
            .up_data  (cell_data[i]),
            .dn_valid (cell_valid[i+1]),
            .dn_ready (cell_ready[i+1]),
            .dn_data  (cell_data[i+1])
        );
    end

    // Output register. NaN, infinity and a zero denominator give zero.
    logic               out_valid_reg;
    logic [DEPTH_W-1:0] depth_out_reg;
    logic               out_ready;

    assign out_ready             = !out_valid_reg || !out_stall;
    assign cell_ready[CELL_COUNT] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= cell_valid[CELL_COUNT];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && cell_valid[CELL_COUNT])
            depth_out_reg <= cell_data[CELL_COUNT].zero ? '0
                                                        : cell_data[CELL_COUNT].quo[DEPTH_W-1:0];
    end

    assign out_valid = out_valid_reg;
    assign depth_out = depth_out_reg;

endmodule

// ===== design/dbl_checker.sv =====
`timescale 1ns / 1ps

module dbl_checker
    import dbl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [DEPTH_W-1:0] depth_out
);

    // A result held by the receiver stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(depth_out))
        else $error("depth_out changed while stalled");

    // The input only stalls when the output is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output was free");

    // An empty pipeline after reset shows no result.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result shown right after reset");

endmodule

bind depth_buffer_linearize_u16 dbl_checker u_dbl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .depth_out (depth_out)
);

// ===== tb/tb_depth_buffer_linearize_u16.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the depth-buffer linearizer. The sender streams depth samples
// and the receiver drains linear depths. Both sides idle in random bursts. For each
// accepted sample, an internal linearizer works out the expected 16-bit depth from its own
// copy of the three plane registers. A checker compares every output transfer with the
// oldest expectation.
module tb_depth_buffer_linearize_u16;
    import dbl_pkg::*;

    // Pipeline latency that settle() waits out once every expected depth has arrived.
    localparam int PIPE_LATENCY = 21;
    // The watchdog trips after this many cycles with no transfer on either channel.
    localparam int STALL_LIMIT  = 2000;
    // The receiver holds off for this long in the back-pressure test.
    localparam int HOLD_CYCLES  = 200;

    // Index 3 decodes to no register, so a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Single-precision bit patterns used by the directed samples.
    localparam logic [SAMPLE_W-1:0] FP_ZERO      = 32'h0000_0000;
    localparam logic [SAMPLE_W-1:0] FP_NEG_ZERO  = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] FP_ONE       = 32'h3F80_0000;
    localparam logic [SAMPLE_W-1:0] FP_NEG_ONE   = 32'hBF80_0000;
    localparam logic [SAMPLE_W-1:0] FP_HALF      = 32'h3F00_0000;
    localparam logic [SAMPLE_W-1:0] FP_QUARTER   = 32'h3E80_0000;
    localparam logic [SAMPLE_W-1:0] FP_TWO       = 32'h4000_0000;
    localparam logic [SAMPLE_W-1:0] FP_BELOW_ONE = 32'h3F7F_FFFF;
    localparam logic [SAMPLE_W-1:0] FP_MAX       = 32'h7F7F_FFFF;
    localparam logic [SAMPLE_W-1:0] FP_POS_INF   = 32'h7F80_0000;
    localparam logic [SAMPLE_W-1:0] FP_NEG_INF   = 32'hFF80_0000;
    localparam logic [SAMPLE_W-1:0] FP_QNAN      = 32'h7FC0_0000;
    localparam logic [SAMPLE_W-1:0] FP_NEG_NAN   = 32'hFFFF_FFFF;
    localparam logic [SAMPLE_W-1:0] FP_LSB_Z24   = 32'h3380_0000;  // 2^-24, one count of z
    localparam logic [SAMPLE_W-1:0] FP_HALF_LSB  = 32'h3300_0000;  // 2^-25, truncates away
    localparam logic [SAMPLE_W-1:0] FP_TINY      = 32'h2EDB_E6FF;  // about 1e-10
    localparam logic [SAMPLE_W-1:0] FP_SUB_MIN   = 32'h0000_0001;
    localparam logic [SAMPLE_W-1:0] FP_SUB_MAX   = 32'h007F_FFFF;
    localparam logic [SAMPLE_W-1:0] FP_NEG_SMALL = 32'hBDCC_CCCD;  // -0.1

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index     = '0;
    logic [CFG_DAT_W-1:0] wr_data      = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  depth_sample = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [DEPTH_W-1:0]   depth_out;

    // The bench's own copy of the plane registers, updated as each write goes out.
    logic [PLANE_W-1:0]   near_cfg  = NEAR_RST;
    logic [PLANE_W-1:0]   far_cfg   = FAR_RST;
    logic [SCALE_W-1:0]   scale_cfg = SCALE_RST;

    // Expected depths of the accepted samples, oldest first.
    logic [DEPTH_W-1:0]   expected_depths[$];
    logic [DEPTH_W-1:0]   want_depth;

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int hold_left      = 0;
    int burst_left     = 0;
    bit idling_on      = 1'b1;

    depth_buffer_linearize_u16 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .depth_sample (depth_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .depth_out    (depth_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Linear depth of one sample under the current plane registers. The sample is clamped
    // to [0,1] and truncated to Q0.24. The distance near*far/(far - z*(far-near)) is then
    // taken exactly as near*far*scale*2^8 over far*(1-z) + near*z, both scaled by 2^24.
    // Finally it is limited to five times the scale and to the 16-bit range.
    function automatic logic [DEPTH_W-1:0] predict_depth(input logic [SAMPLE_W-1:0] bits);
        logic [7:0]        expo;
        logic [23:0]       mant;
        logic [Z24_W-1:0]  z24;
        logic [LIMX_W-1:0] lim;
        logic [127:0]      den;
        logic [127:0]      num;
        logic [127:0]      quo;
        int                shift;
        expo = bits[30:23];
        // NaN and infinity give zero whatever the registers hold.
        if (expo == 8'hFF)
            return '0;
        if (bits[31])
            z24 = '0;
        else if (expo >= 8'd127)
            z24 = Z_ONE;
        else
        begin
            // Subnormals keep the hidden bit clear and use the smallest exponent.
            mant  = (expo == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
            shift = 126 - ((expo == 8'd0) ? 1 : int'(expo));
            z24   = Z24_W'(mant >> shift);
        end
        den = 128'(far_cfg) * 128'(Z_ONE - z24) + 128'(near_cfg) * 128'(z24);
        // A zero denominator only happens with a zero numerator, and it reads as zero.
        if (den == '0)
            return '0;
        lim = LIMX_W'(LIMIT_MULT) * LIMX_W'(scale_cfg);
        if (lim > LIMX_W'(16'hFFFF))
            lim = LIMX_W'(16'hFFFF);
        num = (128'(near_cfg) * 128'(far_cfg) * 128'(scale_cfg)) << NUM_SH;
        quo = num / den;
        if (quo > 128'(lim))
            return lim[DEPTH_W-1:0];
        return quo[DEPTH_W-1:0];
    endfunction

    // Random samples lean toward well-formed depths in (0,1). A share of them sit just under
    // one, where the distance climbs toward far and the limit comes into play. The rest are
    // exact zeros and ones or raw 32-bit patterns, which reach every bit, the sign, NaN and
    // infinity.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom())};
        else if (pick < 75)
            return {1'b0, 8'd126, 7'h7F, 16'($urandom())};
        else if (pick < 80)
            return ($urandom_range(0, 1) == 1) ? FP_ONE : FP_ZERO;
        return $urandom();
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Offers one sample and waits for its transfer. The valid is left high so that the next
    // sample can follow on the very next edge. It is only lowered for a gap or for a pause.
    task automatic send_sample(input logic [SAMPLE_W-1:0] bits);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        depth_sample <= bits;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_depths.push_back(predict_depth(bits));
    endtask

    // Stops offering samples, waits for every outstanding depth, and then gives the
    // pipeline its full latency to go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_depths.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Drives one register write. The enable stays high so that writes can go back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_NEAR:  near_cfg  = data;
            REG_FAR:   far_cfg   = data;
            REG_SCALE: scale_cfg = data[SCALE_W-1:0];
            default:   ;
        endcase
    endtask

    // Loads all three registers with the block idle. It also writes to the unused index,
    // which must leave every register as it was. The scale word is passed whole, so its
    // upper half can carry junk that the block has to drop.
    task automatic load_planes(input logic [PLANE_W-1:0] near_val,
                               input logic [PLANE_W-1:0] far_val,
                               input logic [CFG_DAT_W-1:0] scale_word);
        settle();
        write_reg(REG_NEAR, near_val);
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_FAR, far_val);
        write_reg(REG_SCALE, scale_word);
        wr_en <= 1'b0;
    endtask

    // The reset values (near 0.1, far 10.0, scale 1000) are checked with no write at all.
    // The samples cover both ends of the range, the sign, clamping above one, NaN and
    // infinity, and the truncation of tiny and subnormal values.
    task automatic test_reset_defaults();
        logic [SAMPLE_W-1:0] directed[$];
        directed = '{FP_ZERO, FP_NEG_ZERO, FP_ONE, FP_NEG_ONE, FP_HALF, FP_QUARTER, FP_TWO,
                     FP_BELOW_ONE, FP_MAX, FP_POS_INF, FP_NEG_INF, FP_QNAN, FP_NEG_NAN,
                     FP_LSB_Z24, FP_HALF_LSB, FP_TINY, FP_SUB_MIN, FP_SUB_MAX, FP_NEG_SMALL};
        foreach (directed[i])
            send_sample(directed[i]);
    endtask

    // The register extremes each get a burst of samples. These settings are: the widest
    // and the narrowest planes, far below near, a zero far plane (zero denominator at
    // z = 0), a zero near plane, near equal to far, and a scale of zero whose word
    // carries junk in the upper half.
    task automatic test_register_extremes();
        logic [PLANE_W-1:0]   near_list[8];
        logic [PLANE_W-1:0]   far_list[8];
        logic [CFG_DAT_W-1:0] scale_list[8];
        near_list  = '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0010_0000,
                       32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_8000};
        far_list   = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
                       32'h0000_0000, 32'h0001_0000, 32'h0003_0000, 32'h0100_0000};
        scale_list = '{32'h0000_FFFF, 32'h0000_0001, 32'h0000_03E8, 32'h0000_012C,
                       32'h0000_03E8, 32'h0000_03E8, 32'hFFFF_0000, 32'hABCD_7FFF};
        foreach (near_list[i])
        begin
            load_planes(near_list[i], far_list[i], scale_list[i]);
            send_sample(FP_ZERO);
            send_sample(FP_ONE);
            repeat (48) send_sample(random_sample());
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering samples.
    // The pipeline fills, the input stall rises, and the sample on offer has to sit still
    // until the outputs drain.
    task automatic test_backpressure();
        load_planes(NEAR_RST, FAR_RST, 32'(SCALE_RST));
        hold_left = HOLD_CYCLES;
        repeat (80) send_sample(random_sample());
    endtask

    // Plausible camera setups with random content. The last phase runs with no idling on
    // either side, so back-to-back transfers get their share of the run.
    task automatic test_random_planes();
        logic [PLANE_W-1:0] near_val;
        repeat (11)
        begin
            near_val = $urandom_range(32'h0000_1000, 32'h0004_0000);
            load_planes(near_val, near_val + $urandom_range(1, 32'h0200_0000),
                        {16'($urandom()), 16'($urandom_range(1, 20000))});
            repeat (100) send_sample(random_sample());
        end
        load_planes(NEAR_RST, FAR_RST, 32'(SCALE_RST));
        idling_on = 1'b0;
        repeat (250) send_sample(random_sample());
    endtask

    // Receiver: random stall bursts, the long hold that the back-pressure test asks for,
    // and a steady drain once idling is switched off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_stall  <= 1'b1;
                burst_left = $urandom_range(0, 4);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Checker: every output transfer must match the oldest expected depth.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_depths.size() == 0)
                report_mismatch($sformatf("depth_out %0d with no sample outstanding",
                                          depth_out));
            else
            begin
                want_depth = expected_depths.pop_front();
                if (depth_out !== want_depth)
                    report_mismatch($sformatf("depth_out %0d, expected %0d",
                                              depth_out, want_depth));
            end
        end
    end

    // Watchdog: counts cycles out of reset with no transfer on either channel.
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_planes();

        // Every depth must arrive, and nothing may follow the last one.
        settle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dbl_pkg.sv
design/dbl_front.sv
design/dbl_cell.sv
design/depth_buffer_linearize_u16.sv
design/dbl_checker.sv
tb/tb_depth_buffer_linearize_u16.sv
